// ===== hw/rtl/record_insertion_sorter_top_assert.svh =====
// assertion macros for the record insertion sorter checker
`ifndef RECORD_INSERTION_SORTER_TOP_ASSERT_SVH
`define RECORD_INSERTION_SORTER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define RINS_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rins assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define RINS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rins assertion failed");

`endif

// ===== hw/rtl/rins_pkg.sv =====
// types, constants and key forming for the record insertion sorter
`timescale 1ns / 1ps

package rins_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int KEY_W     = 48;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // sort mode codes
  localparam logic [1:0] MODE_DATE_NEWEST = 2'd0;
  localparam logic [1:0] MODE_DATE_OLDEST = 2'd1;
  localparam logic [1:0] MODE_AMT_LOWEST  = 2'd2;
  localparam logic [1:0] MODE_AMT_HIGHEST = 2'd3;

  // contents of one sorter cell
  typedef struct packed {
    key_t key;
    idx_t idx;
  } entry_t;

  // ascending key for the selected mode
  function automatic key_t form_key(
    input logic [13:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second,
    input logic [47:0] amount,
    input logic [1:0]  mode
  );
    logic [39:0] packed_ts;
    key_t        amt;
    key_t        res;
    packed_ts = {year, month, day, hour, minute, second};
    amt       = {~amount[47], amount[46:0]};
    case (mode)
      MODE_DATE_NEWEST: res = {8'hFF, ~packed_ts};
      MODE_DATE_OLDEST: res = {8'h00, packed_ts};
      MODE_AMT_LOWEST:  res = amt;
      MODE_AMT_HIGHEST: res = ~amt;
      default:          res = amt;
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/rins_rec_if.sv =====
// record channel: valid, ready and the record fields
`timescale 1ns / 1ps

interface rins_rec_if;
  logic        valid;
  logic        ready;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [47:0] amount;
  logic        end_of_list;

  modport source (
    output valid, year, month, day, hour, minute, second, amount, end_of_list,
    input  ready
  );
  modport sink (
    input  valid, year, month, day, hour, minute, second, amount, end_of_list,
    output ready
  );
endinterface

// ===== hw/rtl/rins_res_if.sv =====
// result channel: valid, ready and one sorted index
`timescale 1ns / 1ps

interface rins_res_if;
  logic                valid;
  logic                ready;
  logic [rins_pkg::IDX_W-1:0] item_index;
  logic                last_of_run;
  logic                overflow;

  modport source (
    output valid, item_index, last_of_run, overflow,
    input  ready
  );
  modport sink (
    input  valid, item_index, last_of_run, overflow,
    output ready
  );
endinterface

// ===== hw/rtl/rins_cell.sv =====
// one compare-and-shift cell of the sorter chain
`timescale 1ns / 1ps

module rins_cell (
  input  logic             clk_i,
  input  logic             ins_i,
  input  logic             shift_i,
  input  logic             in_use_i,
  input  rins_pkg::entry_t new_i,
  input  logic             prev_gt_i,
  input  rins_pkg::entry_t prev_i,
  input  rins_pkg::idx_t   next_idx_i,
  output rins_pkg::entry_t entry_o,
  output logic             gt_o
);

  rins_pkg::entry_t entry_q, entry_d;

  // empty cells count as greater so the new entry lands after the tail
  assign gt_o = !in_use_i || (new_i.key < entry_q.key);

  always_comb begin
    entry_d = entry_q;
    if (ins_i) begin
      if (prev_gt_i) begin
        entry_d = prev_i;
      end else if (gt_o) begin
        entry_d = new_i;
      end
    end else if (shift_i) begin
      entry_d.idx = next_idx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== hw/rtl/record_insertion_sorter_top.sv =====
// top level of the record insertion sorter: cell chain, fill count and drain control
//
//  channel    | dir | handshake      | payload
//  -----------+-----+----------------+------------------------------------------
//  rec_i      | in  | valid / ready  | timestamp fields, amount, end_of_list
//  res_o      | out | valid / ready  | item_index, last_of_run, overflow
//  sort_mode  | in  | write enable   | 2-bit sort mode
//
// one record transaction per cycle while a list loads: every cell compares in
// parallel and the chain shifts right by one place in the same edge
// the record marking end of list starts a drain of the n stored records,
// one index per cycle while res_o does not stall, out of cell 0 while the chain shifts left;
// rec_i.ready is low for the whole drain
// a stalled res_o holds the drain; the output register frees the chain from res_o
// reset clears the fill count, overflow flag, drain state and sort mode;
// cell contents are not reset
`timescale 1ns / 1ps

module record_insertion_sorter_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       sort_mode_we_i,
  input  logic [1:0] sort_mode_i,
  rins_rec_if.sink   rec_i,
  rins_res_if.source res_o
);

  localparam int N = rins_pkg::MAX_ITEMS;

  // configuration
  logic [1:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rins_pkg::MODE_DATE_NEWEST;
    end else if (sort_mode_we_i) begin
      mode_q <= sort_mode_i;
    end
  end

  // control state
  rins_pkg::cnt_t count_q, count_d;
  rins_pkg::cnt_t remain_q, remain_d;
  logic           drain_q, drain_d;
  logic           ovf_q, ovf_d;
  logic           drain_ovf_q, drain_ovf_d;

  // output register
  logic           out_valid_q, out_valid_d;
  rins_pkg::idx_t out_idx_q, out_idx_d;
  logic           out_last_q, out_last_d;
  logic           out_ovf_q, out_ovf_d;

  logic             accept;
  logic             full;
  logic             ins;
  logic             step;
  rins_pkg::entry_t new_entry;

  // chain wiring
  rins_pkg::entry_t entries [N];
  logic             gts     [N];

  assign rec_i.ready = !drain_q;
  assign accept      = rec_i.valid && rec_i.ready;
  assign full        = (count_q == rins_pkg::cnt_t'(N));
  assign ins         = accept && !full;
  // one drain step whenever the output register is free or being emptied
  assign step        = drain_q && (!out_valid_q || res_o.ready);

  assign new_entry.key = rins_pkg::form_key(rec_i.year, rec_i.month, rec_i.day, rec_i.hour,
                                            rec_i.minute, rec_i.second, rec_i.amount, mode_q);
  assign new_entry.idx = count_q[rins_pkg::IDX_W-1:0];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic             prev_gt;
    rins_pkg::entry_t prev_entry;
    rins_pkg::idx_t   next_idx;
    logic             in_use;

    assign in_use = (count_q > rins_pkg::cnt_t'(i));

    if (i == 0) begin : g_head
      assign prev_gt    = 1'b0;
      assign prev_entry = new_entry;
    end else begin : g_body
      assign prev_gt    = gts[i-1];
      assign prev_entry = entries[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign next_idx = '0;
    end else begin : g_inner
      assign next_idx = entries[i+1].idx;
    end

    rins_cell u_cell (
      .clk_i      (clk_i),
      .ins_i      (ins),
      .shift_i    (step),
      .in_use_i   (in_use),
      .new_i      (new_entry),
      .prev_gt_i  (prev_gt),
      .prev_i     (prev_entry),
      .next_idx_i (next_idx),
      .entry_o    (entries[i]),
      .gt_o       (gts[i])
    );
  end

  always_comb begin
    count_d     = count_q;
    remain_d    = remain_q;
    drain_d     = drain_q;
    ovf_d       = ovf_q;
    drain_ovf_d = drain_ovf_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;

    if (accept) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + rins_pkg::cnt_t'(1);
      end
      if (rec_i.end_of_list) begin
        // list closed: hand the count and flag to the drain
        drain_d     = 1'b1;
        remain_d    = count_d;
        drain_ovf_d = ovf_d;
        count_d     = '0;
        ovf_d       = 1'b0;
      end
    end

    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (step) begin
      out_valid_d = 1'b1;
      out_idx_d   = entries[0].idx;
      out_last_d  = (remain_q == rins_pkg::cnt_t'(1));
      out_ovf_d   = drain_ovf_q;
      remain_d    = remain_q - rins_pkg::cnt_t'(1);
      if (remain_q == rins_pkg::cnt_t'(1)) begin
        drain_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      remain_q    <= '0;
      drain_q     <= 1'b0;
      ovf_q       <= 1'b0;
      drain_ovf_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      remain_q    <= remain_d;
      drain_q     <= drain_d;
      ovf_q       <= ovf_d;
      drain_ovf_q <= drain_ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.item_index  = out_idx_q;
  assign res_o.last_of_run = out_last_q;
  assign res_o.overflow    = out_ovf_q;

endmodule

// ===== hw/rtl/rins_checker.sv =====
// port-level checker for the record insertion sorter, bound to the top level
`timescale 1ns / 1ps

`include "record_insertion_sorter_top_assert.svh"

module rins_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 rec_valid_i,
  input logic                 rec_ready_i,
  input logic                 rec_eol_i,
  input logic                 res_valid_i,
  input logic                 res_ready_i,
  input logic [rins_pkg::IDX_W-1:0] res_index_i,
  input logic                 res_last_i,
  input logic                 res_ovf_i
);

  // index and flags of the result on offer
  logic [rins_pkg::IDX_W+1:0] res_payload;

  assign res_payload = {res_index_i, res_last_i, res_ovf_i};

  // a stalled result keeps its index and flags
  `RINS_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(res_payload))

  // closing a list stops record intake for the drain
  `RINS_ASSERT_NEXT(a_eol_stalls, rec_valid_i && rec_ready_i && rec_eol_i, !rec_ready_i)

  // while records are taken only the final result of a run may be pending
  `RINS_ASSERT(a_idle_only_last, rec_ready_i && res_valid_i, res_last_i)

  // a result that is not the last one is always followed by more drain work
  `RINS_ASSERT(a_mid_run_busy, res_valid_i && !res_last_i, !rec_ready_i)

endmodule

bind record_insertion_sorter_top rins_checker u_rins_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rec_valid_i (rec_i.valid),
  .rec_ready_i (rec_i.ready),
  .rec_eol_i   (rec_i.end_of_list),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_index_i (res_o.item_index),
  .res_last_i  (res_o.last_of_run),
  .res_ovf_i   (res_o.overflow)
);
